[sv/c_string_literal_escaper_unit_defines.svh]
// ----------------------------------------------------------------------------
// c_string_literal_escaper_unit_defines
// Assertion macros shared by the escaper RTL.
// ----------------------------------------------------------------------------
`ifndef C_STRING_LITERAL_ESCAPER_UNIT_DEFINES_SVH
`define C_STRING_LITERAL_ESCAPER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CSLE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("csle assertion failed");

// next-cycle implication, checked outside reset
`define CSLE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("csle assertion failed");

`endif

[sv/csle_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csle_pkg
// Types, character codes and lookup functions of the string literal escaper.
// ----------------------------------------------------------------------------
package csle_pkg;

    localparam logic [7:0] LINE_RESET  = 8'd80;
    localparam logic [7:0] LINE_MAX    = 8'd128;
    localparam logic [7:0] PRINT_LOW   = 8'd32;
    localparam logic [7:0] PRINT_HIGH  = 8'd126;
    localparam logic [7:0] NAMED_LOW   = 8'd7;
    localparam logic [7:0] NAMED_HIGH  = 8'd13;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_A_OFS  = 8'h57;   // 'a' - 10

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_file;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } t_out_word;

    typedef enum logic [1:0] {
        ESC_PLAIN,
        ESC_SLASH,
        ESC_NAMED,
        ESC_HEX
    } t_esc;

    // one classified byte, handed from front to back
    typedef struct packed {
        logic       open_line;
        logic       mode_break;
        t_esc       kind;
        logic [7:0] data;
        logic       close_line;
    } t_desc;

    typedef enum logic [1:0] {
        PH_OPEN,
        PH_BRK,
        PH_ESC,
        PH_CLOSE
    } t_phase;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // letter for control codes 7..13, indexed from 0
    function automatic logic [7:0] named_letter(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h61; // a
            3'd1:    ch = 8'h62; // b
            3'd2:    ch = 8'h74; // t
            3'd3:    ch = 8'h6E; // n
            3'd4:    ch = 8'h76; // v
            3'd5:    ch = 8'h66; // f
            3'd6:    ch = 8'h72; // r
            default: ch = 8'h72;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = CH_ZERO + {4'h0, nib};
        end else begin
            ch = CH_A_OFS + {4'h0, nib};
        end
        return ch;
    endfunction

endpackage

[sv/c_string_literal_escaper_unit.sv]
// An accepted word is written into the queue; the back end takes it from the head
// and registers one character per cycle while the output is not held. A byte
// turns into 1 to 12 characters (1 plain, 2 short escape, 4 hex, +3 line open,
// +3 mode break, +2 line close), set by the character sequencer in the back end.
// Input is taken while the queue has room. Reset (i_rst_n low, synchronous):
// queue emptied, hex mode and line position cleared, line_bytes back to 80.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_string_literal_escaper_unit
// Turns raw file bytes into the characters of a C string literal.
// ----------------------------------------------------------------------------
`include "c_string_literal_escaper_unit_defines.svh"

module c_string_literal_escaper_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  csle_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output csle_pkg::t_out_word o_out_word
);

    csle_pkg::t_q_stat w_q_stat;
    csle_pkg::t_desc   w_push_desc;
    csle_pkg::t_desc   w_head_desc;
    logic              w_push;
    logic              w_pop;

    csle_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .i_q_stat    (w_q_stat),
        .o_push      (w_push),
        .o_desc      (w_push_desc)
    );

    csle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_push_desc),
        .i_pop   (w_pop),
        .o_rdata (w_head_desc),
        .o_stat  (w_q_stat)
    );

    csle_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc       (w_head_desc),
        .i_desc_valid (!w_q_stat.empty),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_word   (o_out_word)
    );

    // a word mid-sequence keeps the output stream going without a bubble
    `CSLE_ASSERT_NEXT(a_no_bubble, o_out_valid && i_out_ready && !o_out_word.last_char, o_out_valid)
    // an accepted word is always in the queue the next cycle
    `CSLE_ASSERT_NEXT(a_push_lands, i_in_valid && o_in_ready, !w_q_stat.empty)
    // a pop only happens on a real, queued word
    `CSLE_ASSERT_SAME(a_pop_nonempty, w_pop, !w_q_stat.empty && !(w_q_stat.full && w_q_stat.empty))

endmodule

[sv/csle_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csle_front
// Accepts input words, classifies the byte and tracks line and hex state.
// ----------------------------------------------------------------------------
module csle_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  csle_pkg::t_in_word i_in_word,
    input  csle_pkg::t_q_stat  i_q_stat,
    output logic               o_push,
    output csle_pkg::t_desc    o_desc
);

    logic [7:0] r_line_bytes;
    logic       r_hex_mode;
    logic [6:0] r_line_pos;
    logic [6:0] n_line_pos;

    csle_pkg::t_esc w_kind;
    logic [7:0]     w_limit;
    logic [7:0]     w_pos_inc;
    logic           w_is_hex;
    logic           w_close;

    always_comb begin
        if (i_in_word.in_byte == csle_pkg::CH_BSLASH ||
            i_in_word.in_byte == csle_pkg::CH_QUOTE) begin
            w_kind = csle_pkg::ESC_SLASH;
        end else if (i_in_word.in_byte >= csle_pkg::NAMED_LOW &&
                     i_in_word.in_byte <= csle_pkg::NAMED_HIGH) begin
            w_kind = csle_pkg::ESC_NAMED;
        end else if (i_in_word.in_byte >= csle_pkg::PRINT_LOW &&
                     i_in_word.in_byte <= csle_pkg::PRINT_HIGH) begin
            w_kind = csle_pkg::ESC_PLAIN;
        end else begin
            w_kind = csle_pkg::ESC_HEX;
        end
    end

    always_comb begin
        if (r_line_bytes == 8'd0) begin
            w_limit = 8'd1;
        end else if (r_line_bytes > csle_pkg::LINE_MAX) begin
            w_limit = csle_pkg::LINE_MAX;
        end else begin
            w_limit = r_line_bytes;
        end
    end

    assign w_is_hex  = (w_kind == csle_pkg::ESC_HEX);
    assign w_pos_inc = {1'b0, r_line_pos} + 8'd1;
    assign w_close   = i_in_word.end_of_file || (w_pos_inc >= w_limit);
    assign n_line_pos = w_close ? 7'd0 : w_pos_inc[6:0];

    assign o_in_ready = !i_q_stat.full;
    assign o_push     = i_in_valid && o_in_ready;

    always_comb begin
        o_desc.open_line  = (r_line_pos == 7'd0);
        o_desc.mode_break = (w_is_hex != r_hex_mode);
        o_desc.kind       = w_kind;
        o_desc.data       = i_in_word.in_byte;
        o_desc.close_line = w_close;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_bytes <= csle_pkg::LINE_RESET;
        end else if (i_cfg_we) begin
            r_line_bytes <= i_cfg_wdata;
        end
    end

    // hex mode survives end of file; reset clears it, and each accepted byte sets it to its own kind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hex_mode <= 1'b0;
            r_line_pos <= 7'd0;
        end else if (o_push) begin
            r_hex_mode <= w_is_hex;
            r_line_pos <= n_line_pos;
        end
    end

endmodule

[sv/csle_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csle_queue
// Small register FIFO of classified words between front and back.
// ----------------------------------------------------------------------------
module csle_queue #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  csle_pkg::t_desc   i_wdata,
    input  logic              i_pop,
    output csle_pkg::t_desc   o_rdata,
    output csle_pkg::t_q_stat o_stat
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    csle_pkg::t_desc r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [AW-1:0]   n_wr_ptr;
    logic [AW-1:0]   n_rd_ptr;

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_rdata      = r_mem[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[sv/csle_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csle_back
// Walks one classified word through open, break, escape and close phases,
// one character per cycle into the output register while the output is not held.
// ----------------------------------------------------------------------------
module csle_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  csle_pkg::t_desc     i_desc,
    input  logic                i_desc_valid,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output csle_pkg::t_out_word o_out_word
);

    csle_pkg::t_phase r_phase;
    csle_pkg::t_phase n_phase;
    csle_pkg::t_phase w_eff;
    logic [1:0]       r_sub;
    logic [1:0]       n_sub;
    logic [1:0]       w_last_sub;
    logic             w_at_end;
    logic             w_last;
    logic             w_step;
    logic [7:0]       w_char;
    logic [7:0]       w_named_idx;

    logic                r_out_valid;
    csle_pkg::t_out_word r_out_word;

    assign w_step = i_desc_valid && (!r_out_valid || i_out_ready);
    assign o_pop  = w_step && w_last;

    // skip phases this word does not use
    always_comb begin
        unique case (r_phase)
            csle_pkg::PH_OPEN: begin
                if (i_desc.open_line) begin
                    w_eff = csle_pkg::PH_OPEN;
                end else if (i_desc.mode_break) begin
                    w_eff = csle_pkg::PH_BRK;
                end else begin
                    w_eff = csle_pkg::PH_ESC;
                end
            end
            csle_pkg::PH_BRK: begin
                w_eff = i_desc.mode_break ? csle_pkg::PH_BRK : csle_pkg::PH_ESC;
            end
            default: w_eff = r_phase;
        endcase
    end

    always_comb begin
        unique case (w_eff)
            csle_pkg::PH_OPEN, csle_pkg::PH_BRK: w_last_sub = 2'd2;
            csle_pkg::PH_CLOSE:                  w_last_sub = 2'd1;
            default: begin
                unique case (i_desc.kind)
                    csle_pkg::ESC_PLAIN: w_last_sub = 2'd0;
                    csle_pkg::ESC_HEX:   w_last_sub = 2'd3;
                    default:             w_last_sub = 2'd1;
                endcase
            end
        endcase
    end

    assign w_at_end = (r_sub == w_last_sub);
    assign w_last   = w_at_end && ((w_eff == csle_pkg::PH_CLOSE) ||
                      (w_eff == csle_pkg::PH_ESC && !i_desc.close_line));

    // next state
    always_comb begin
        n_phase = r_phase;
        n_sub   = r_sub;
        if (w_step) begin
            if (w_last) begin
                n_phase = csle_pkg::PH_OPEN;
                n_sub   = 2'd0;
            end else if (w_at_end) begin
                n_sub = 2'd0;
                unique case (w_eff)
                    csle_pkg::PH_OPEN: n_phase = csle_pkg::PH_BRK;
                    csle_pkg::PH_BRK:  n_phase = csle_pkg::PH_ESC;
                    default:           n_phase = csle_pkg::PH_CLOSE;
                endcase
            end else begin
                n_sub = r_sub + 2'd1;
            end
        end
    end

    assign w_named_idx = i_desc.data - csle_pkg::NAMED_LOW;

    // character for the current phase and step
    always_comb begin
        unique case (w_eff)
            csle_pkg::PH_OPEN: begin
                w_char = (r_sub == 2'd2) ? csle_pkg::CH_QUOTE : csle_pkg::CH_SPACE;
            end
            csle_pkg::PH_BRK: begin
                w_char = (r_sub == 2'd1) ? csle_pkg::CH_SPACE : csle_pkg::CH_QUOTE;
            end
            csle_pkg::PH_CLOSE: begin
                w_char = (r_sub == 2'd0) ? csle_pkg::CH_QUOTE : csle_pkg::CH_NL;
            end
            default: begin
                unique case (i_desc.kind)
                    csle_pkg::ESC_PLAIN: w_char = i_desc.data;
                    csle_pkg::ESC_SLASH: begin
                        w_char = (r_sub == 2'd0) ? csle_pkg::CH_BSLASH : i_desc.data;
                    end
                    csle_pkg::ESC_NAMED: begin
                        w_char = (r_sub == 2'd0) ? csle_pkg::CH_BSLASH :
                                 csle_pkg::named_letter(w_named_idx[2:0]);
                    end
                    default: begin
                        case (r_sub)
                            2'd0:    w_char = csle_pkg::CH_BSLASH;
                            2'd1:    w_char = csle_pkg::CH_X;
                            2'd2:    w_char = csle_pkg::hex_char(i_desc.data[7:4]);
                            default: w_char = csle_pkg::hex_char(i_desc.data[3:0]);
                        endcase
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= csle_pkg::PH_OPEN;
            r_sub       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_sub   <= n_sub;
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_word.out_char  <= w_char;
            r_out_word.last_char <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

[sim/c_string_literal_escaper_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_string_literal_escaper_unit_test
// Self-checking bench for the C string literal escaper. Bytes go in on a
// valid/ready channel while a behavioral copy of the escaper builds the
// expected characters. Every character that comes out is compared with the
// oldest one still expected. Both channels idle at random. The line length
// register is changed between phases, including to its extremes and in the
// middle of an open line.
// ----------------------------------------------------------------------------
module c_string_literal_escaper_unit_test;

    localparam string ESC_LETTERS = "abtnvfr";
    localparam string HEX_DIGITS  = "0123456789abcdef";
    localparam int    STALL_LIMIT = 2000;
    localparam int    SETTLE_CYCLES = 4;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic [7:0]          i_cfg_wdata = 8'd0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    csle_pkg::t_in_word  i_in_word   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    csle_pkg::t_out_word o_out_word;

    // shadow of the escaper state
    logic [7:0] line_len  = csle_pkg::LINE_RESET;
    logic [6:0] line_fill = 7'd0;
    logic       hex_run   = 1'b0;

    csle_pkg::t_out_word literal_chars [$];
    csle_pkg::t_out_word want;
    int                  fail_count  = 0;
    int                  idle_cycles = 0;
    bit                  steady      = 1'b0;

    c_string_literal_escaper_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always #2 i_clk = ~i_clk;

    // characters one byte turns into, last one flagged
    task automatic expect_literal(input csle_pkg::t_in_word w);
        logic [7:0] chars [$];
        logic [7:0] esc [$];
        logic [7:0] lim;
        logic [7:0] next_fill;
        logic [7:0] b;
        logic       now_hex;
        b = w.in_byte;
        lim = (line_len == 8'd0) ? 8'd1 :
              (line_len > csle_pkg::LINE_MAX) ? csle_pkg::LINE_MAX : line_len;
        if (line_fill == 7'd0) begin
            chars.insert(chars.size(), csle_pkg::CH_SPACE);
            chars.insert(chars.size(), csle_pkg::CH_SPACE);
            chars.insert(chars.size(), csle_pkg::CH_QUOTE);
        end
        if (b == csle_pkg::CH_BSLASH || b == csle_pkg::CH_QUOTE) begin
            esc = '{csle_pkg::CH_BSLASH, b};
        end else if (b >= csle_pkg::NAMED_LOW && b <= csle_pkg::NAMED_HIGH) begin
            esc = '{csle_pkg::CH_BSLASH, ESC_LETTERS[int'(b - csle_pkg::NAMED_LOW)]};
        end else if (b >= csle_pkg::PRINT_LOW && b <= csle_pkg::PRINT_HIGH) begin
            esc = '{b};
        end else begin
            esc = '{csle_pkg::CH_BSLASH, csle_pkg::CH_X,
                    HEX_DIGITS[int'(b[7:4])], HEX_DIGITS[int'(b[3:0])]};
        end
        now_hex = (esc.size() == 4);
        // kind change: split the literal so a hex digit cannot run on
        if (now_hex != hex_run) begin
            hex_run = now_hex;
            chars.insert(chars.size(), csle_pkg::CH_QUOTE);
            chars.insert(chars.size(), csle_pkg::CH_SPACE);
            chars.insert(chars.size(), csle_pkg::CH_QUOTE);
        end
        foreach (esc[i]) chars.insert(chars.size(), esc[i]);
        next_fill = {1'b0, line_fill} + 8'd1;
        if (w.end_of_file || next_fill >= lim) begin
            chars.insert(chars.size(), csle_pkg::CH_QUOTE);
            chars.insert(chars.size(), csle_pkg::CH_NL);
            line_fill = 7'd0;
        end else begin
            line_fill = next_fill[6:0];
        end
        foreach (chars[i]) begin
            literal_chars.insert(literal_chars.size(),
                                 csle_pkg::t_out_word'{out_char: chars[i],
                                                       last_char: (i == chars.size() - 1)});
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                expect_literal(i_in_word);
            end
            if (o_out_valid && i_out_ready) begin
                if (literal_chars.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected word, expected none actual %h", $time,
                             o_out_word);
                end else begin
                    want = literal_chars.pop_front();
                    if (o_out_word.out_char !== want.out_char) begin
                        fail_count++;
                        $display("%0t: out_char mismatch, expected %h actual %h", $time,
                                 want.out_char, o_out_word.out_char);
                    end
                    if (o_out_word.last_char !== want.last_char) begin
                        fail_count++;
                        $display("%0t: last_char mismatch, expected %b actual %b", $time,
                                 want.last_char, o_out_word.last_char);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= 30);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("c_string_literal_escaper_unit verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // valid is only dropped when a gap is taken
    task automatic send_byte(input logic [7:0] b, input logic eof);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(99) < 30) gap = $urandom_range(3, 1);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= csle_pkg::t_in_word'{in_byte: b, end_of_file: eof};
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain_literal();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (literal_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // only while idle
    task automatic write_line_bytes(input logic [7:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        line_len = v;
    endtask

    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        case ($urandom_range(3))
            0: b = 8'($urandom_range(255));
            1: b = 8'($urandom_range(csle_pkg::PRINT_HIGH, csle_pkg::PRINT_LOW));
            2: begin
                case ($urandom_range(2))
                    0: b = csle_pkg::CH_BSLASH;
                    1: b = csle_pkg::CH_QUOTE;
                    default: b = 8'($urandom_range(csle_pkg::NAMED_HIGH,
                                                   csle_pkg::NAMED_LOW));
                endcase
            end
            default: b = $urandom_range(1) ?
                         8'($urandom_range(csle_pkg::PRINT_LOW - 1, 0)) :
                         8'($urandom_range(255, csle_pkg::PRINT_HIGH + 1));
        endcase
        return b;
    endfunction

    task automatic test_byte_classes();
        logic [7:0] bytes [$];
        bytes = '{8'h00, 8'hFF, csle_pkg::PRINT_LOW, csle_pkg::PRINT_HIGH,
                  csle_pkg::PRINT_LOW - 8'd1, csle_pkg::PRINT_HIGH + 8'd1, 8'h80,
                  csle_pkg::CH_BSLASH, csle_pkg::CH_QUOTE};
        for (int c = int'(csle_pkg::NAMED_LOW); c <= int'(csle_pkg::NAMED_HIGH); c++) begin
            bytes.insert(bytes.size(), c[7:0]);
        end
        foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
        drain_literal();
    endtask

    // hex mode carries over a file end
    task automatic test_file_end_keeps_mode();
        send_byte(8'h80, 1'b1);
        send_byte(8'h01, 1'b1);
        drain_literal();
    endtask

    task automatic test_line_length_extremes();
        write_line_bytes(8'd0);
        repeat (2) send_byte(pick_byte(), 1'b0);
        drain_literal();
        write_line_bytes(8'd1);
        repeat (2) send_byte(pick_byte(), 1'b0);
        drain_literal();
    endtask

    // shrinking the length closes the open line on its next word
    task automatic test_midline_shrink();
        write_line_bytes(csle_pkg::LINE_RESET);
        repeat (3) send_byte(pick_byte(), 1'b0);
        drain_literal();
        write_line_bytes(8'd2);
        send_byte(pick_byte(), 1'b0);
        send_byte(pick_byte(), 1'b0);
        drain_literal();
        write_line_bytes(8'd0);
        send_byte(pick_byte(), 1'b0);
        drain_literal();
    endtask

    // above 128 acts as 128
    task automatic test_longest_line();
        write_line_bytes(8'd255);
        repeat (130) send_byte(pick_byte(), 1'b0);
        send_byte(pick_byte(), 1'b1);
        drain_literal();
        write_line_bytes(csle_pkg::LINE_MAX);
        repeat (5) send_byte(pick_byte(), 1'b0);
        drain_literal();
    endtask

    task automatic test_random_mix(input logic [7:0] len, input int count, input bit calm);
        write_line_bytes(len);
        steady = calm;
        repeat (count) send_byte(pick_byte(), $urandom_range(99) < 6);
        drain_literal();
        steady = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_byte_classes();
        test_file_end_keeps_mode();
        test_line_length_extremes();
        test_midline_shrink();
        test_longest_line();
        test_random_mix(csle_pkg::LINE_RESET, 60, 1'b0);
        test_random_mix(8'd1, 50, 1'b0);
        test_random_mix(8'($urandom_range(20, 2)), 60, 1'b1);
        test_random_mix(8'd0, 40, 1'b0);
        test_random_mix(8'($urandom_range(255, 1)), 60, 1'b0);
        test_random_mix(8'd3, 40, 1'b0);
        if (fail_count == 0) begin
            $display("c_string_literal_escaper_unit verification clean");
        end else begin
            $display("c_string_literal_escaper_unit verification failed");
        end
        $finish;
    end

endmodule
